>>> hw/rtl/lnf_pkg.sv
// shared constants, command codes and controller/datapath interface types
`default_nettype none

package lnf_pkg;

  localparam int MAX_LEN_DEF = 64;

  // fixed widths of the arithmetic
  localparam int SD_W    = 24;           // deviation in units of 2^-8
  localparam int VAR_W   = 32;           // variance plus epsilon
  localparam int SQ_IN_W = VAR_W + 16;   // radicand
  localparam int Y_W     = 35;           // clamped normalized value, signed
  localparam int ACC_W   = Y_W + 17;     // affine sum before rounding

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AFFINE  = 1'd1;

  localparam logic [15:0] EPSILON_RST = 16'd1;
  localparam logic        AFFINE_RST  = 1'b1;

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_PROD      = 5'd1;
  localparam logic [OP_W-1:0] OP_DIFF      = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV_VAR   = 5'd3;
  localparam logic [OP_W-1:0] OP_TAKE_VAR  = 5'd4;
  localparam logic [OP_W-1:0] OP_SQRT      = 5'd5;
  localparam logic [OP_W-1:0] OP_TAKE_SD   = 5'd6;
  localparam logic [OP_W-1:0] OP_DIV_RSTD  = 5'd7;
  localparam logic [OP_W-1:0] OP_TAKE_RSTD = 5'd8;
  localparam logic [OP_W-1:0] OP_DIV_MEAN  = 5'd9;
  localparam logic [OP_W-1:0] OP_TAKE_MEAN = 5'd10;
  localparam logic [OP_W-1:0] OP_NX        = 5'd11;
  localparam logic [OP_W-1:0] OP_DIV_Y     = 5'd12;
  localparam logic [OP_W-1:0] OP_TAKE_Y    = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL       = 5'd14;
  localparam logic [OP_W-1:0] OP_SUM       = 5'd15;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd16;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
  } lnf_cmd_t;

  typedef struct packed {
    logic full;
    logic div_done;
    logic sqrt_done;
    logic last;
    logic out_free;
  } lnf_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/lnf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lnf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lnf_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module lnf_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 31
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_r, quo_r[NUM_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
    rem_nxt   = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt   = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/lnf_sqrt.sv
// digit by digit integer square root, one root bit per cycle
`default_nettype none

module lnf_sqrt #(
  parameter int IN_W = 48
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [IN_W-1:0]     radicand,
  output logic                     done,
  output logic      [IN_W/2-1:0]   root
);

  localparam int RT_W  = IN_W / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [IN_W-1:0]  val_r;
  logic [RT_W:0]    rem_r, rem_nxt;
  logic [RT_W-1:0]  root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [RT_W+2:0]  rem_sh;
  logic [RT_W+2:0]  trial;
  logic [RT_W+2:0]  rem_sub;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, val_r[IN_W-1:IN_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    rem_sub  = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? rem_sub[RT_W:0] : rem_sh[RT_W:0];
    root_nxt = {root_r[RT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(RT_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      val_r  <= {val_r[IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

>>> hw/rtl/lnf_datapath.sv
// slice buffer, running sums, statistics and per element normalization
`default_nettype none

module lnf_datapath #(
  parameter int MAX_LEN = lnf_pkg::MAX_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lnf_pkg::lnf_cmd_t              cmd,
  output lnf_pkg::lnf_stat_t                  stat,
  input  wire logic signed [15:0]             in_sample,
  input  wire logic signed [15:0]             in_scale_weight,
  input  wire logic signed [15:0]             in_shift_bias,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [15:0]                  out_normalized,
  output logic signed [15:0]                  out_slice_average,
  output logic        [15:0]                  out_inverse_deviation,
  output logic                                out_final_result
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int AW    = $clog2(MAX_LEN);
  localparam int SUM_W = 16 + CNT_W;
  localparam int SQ_W  = 30 + CNT_W;
  localparam int D2_W  = 2 * CNT_W + 30;
  localparam int NN_W  = 2 * CNT_W;
  localparam int NSD_W = CNT_W + lnf_pkg::SD_W;
  localparam int NX_W  = CNT_W + 17;
  localparam int NUM_A = CNT_W + 41;
  localparam int NUM_W = (NUM_A > D2_W) ? NUM_A : D2_W;
  localparam int DEN_W = (NSD_W > NN_W) ? NSD_W : NN_W;
  localparam int Y_W   = lnf_pkg::Y_W;
  localparam int ACC_W = lnf_pkg::ACC_W;
  localparam int SD_W  = lnf_pkg::SD_W;
  localparam int VAR_W = lnf_pkg::VAR_W;

  // configuration
  logic [15:0] eps_r;
  logic        aff_r;

  // accumulation
  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic signed [31:0]      sq_prod;

  // slice statistics
  logic [D2_W-1:0]           nq_r;
  logic signed [2*SUM_W-1:0] ss_r;
  logic [NN_W-1:0]           nn_r;
  logic [D2_W-1:0]           d2_r;
  logic signed [D2_W:0]      dd;
  logic [VAR_W-1:0]          var_r;
  logic [SD_W-1:0]           sd_r;
  logic [NSD_W-1:0]          nsd_r;
  logic [15:0]               rstd_r;
  logic [15:0]               mean_r;
  logic [SUM_W-1:0]          s_mag;

  // element pipeline
  logic [AW-1:0]           idx_r;
  logic [47:0]             rdata;
  logic signed [15:0]      rd_sample;
  logic signed [NX_W-1:0]  nx_r;
  logic signed [15:0]      w_r;
  logic signed [15:0]      b_r;
  logic signed [NX_W:0]    t_val;
  logic [NX_W-1:0]         t_mag;
  logic                    ysign_r;
  logic signed [Y_W-1:0]   y_r;
  logic [Y_W-1:0]          y_abs;
  logic signed [Y_W+15:0]  prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]        a_mag;
  logic [ACC_W:0]          a_rnd;
  logic [ACC_W-16:0]       r_mag;
  logic [15:0]             res_val;

  // divider shared by all divisions, square root unit
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  logic             sqrt_done;
  logic [SD_W-1:0]  root;

  // output register
  logic              out_valid_r;
  logic signed [15:0] out_norm_r;
  logic signed [15:0] out_avg_r;
  logic [15:0]       out_inv_r;
  logic              out_fin_r;
  logic              out_free;
  logic              last;
  logic              do_load;

  lnf_ram #(
    .WIDTH (48),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_sample, in_scale_weight, in_shift_bias}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  lnf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  lnf_sqrt #(
    .IN_W (lnf_pkg::SQ_IN_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == lnf_pkg::OP_SQRT),
    .radicand ({var_r, 16'b0}),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    sq_prod   = in_sample * in_sample;
    rd_sample = $signed(rdata[47:32]);
    dd        = $signed({1'b0, nq_r}) - $signed({1'b0, ss_r[D2_W-1:0]});
    s_mag     = sum_r[SUM_W-1] ? SUM_W'($unsigned(-sum_r)) : $unsigned(sum_r);
    t_val     = (NX_W+1)'(nx_r) - (NX_W+1)'(sum_r);
    t_mag     = t_val[NX_W] ? NX_W'($unsigned(-t_val)) : $unsigned(t_val[NX_W-1:0]);
    // clamp magnitude at 2^33
    y_abs     = (quo > NUM_W'(34'h2_0000_0000)) ? Y_W'(34'h2_0000_0000) : quo[Y_W-1:0];
    a_mag     = acc_r[ACC_W-1] ? ACC_W'($unsigned(-acc_r)) : $unsigned(acc_r);
    a_rnd     = {1'b0, a_mag} + (ACC_W+1)'(32768);
    r_mag     = a_rnd[ACC_W:16];
    if (acc_r[ACC_W-1]) begin
      res_val = (r_mag > (ACC_W-15)'(32768)) ? 16'h8000 : 16'(-r_mag[15:0]);
    end else begin
      res_val = (r_mag > (ACC_W-15)'(32767)) ? 16'h7FFF : r_mag[15:0];
    end
  end

  // divider operand selection, rounding offsets added up front except for the variance
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      lnf_pkg::OP_DIV_VAR: begin
        div_start = 1'b1;
        div_num   = NUM_W'(d2_r);
        div_den   = DEN_W'(nn_r);
      end
      lnf_pkg::OP_DIV_RSTD: begin
        div_start = 1'b1;
        div_num   = NUM_W'(25'h100_0000) + NUM_W'(sd_r >> 1);
        div_den   = DEN_W'(sd_r);
      end
      lnf_pkg::OP_DIV_MEAN: begin
        div_start = 1'b1;
        div_num   = NUM_W'(s_mag) + NUM_W'(count_r >> 1);
        div_den   = DEN_W'(count_r);
      end
      lnf_pkg::OP_DIV_Y: begin
        div_start = 1'b1;
        div_num   = NUM_W'({t_mag, 24'b0}) + NUM_W'(nsd_r >> 1);
        div_den   = DEN_W'(nsd_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign last     = (CNT_W'(idx_r) == count_r - 1'b1);
  assign do_load  = (cmd.op == lnf_pkg::OP_LOAD);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= lnf_pkg::EPSILON_RST;
      aff_r       <= lnf_pkg::AFFINE_RST;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lnf_pkg::CFG_EPSILON: eps_r <= cfg_data;
          lnf_pkg::CFG_AFFINE:  aff_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SUM_W'(in_sample);
        sq_r    <= sq_r + SQ_W'($unsigned(sq_prod));
      end
      if (cmd.op == lnf_pkg::OP_PROD) begin
        idx_r <= '0;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 1'b1;
        if (last) begin
          count_r <= '0;
          sum_r   <= '0;
          sq_r    <= '0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      lnf_pkg::OP_PROD: begin
        nq_r <= count_r * sq_r;
        ss_r <= sum_r * sum_r;
        nn_r <= count_r * count_r;
      end
      lnf_pkg::OP_DIFF: begin
        d2_r <= dd[D2_W] ? D2_W'($unsigned(-dd)) : $unsigned(dd[D2_W-1:0]);
      end
      lnf_pkg::OP_TAKE_VAR: begin
        var_r <= quo[VAR_W-1:0] + VAR_W'(eps_r);
      end
      lnf_pkg::OP_TAKE_SD: begin
        sd_r <= (root == '0) ? SD_W'(1) : root;
      end
      lnf_pkg::OP_TAKE_RSTD: begin
        rstd_r <= (quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
        nsd_r  <= count_r * sd_r;
      end
      lnf_pkg::OP_TAKE_MEAN: begin
        mean_r <= sum_r[SUM_W-1] ? 16'(-quo[15:0]) : quo[15:0];
      end
      lnf_pkg::OP_NX: begin
        nx_r <= NX_W'($signed({1'b0, count_r}) * NX_W'(rd_sample));
        w_r  <= $signed(rdata[31:16]);
        b_r  <= $signed(rdata[15:0]);
      end
      lnf_pkg::OP_DIV_Y: begin
        ysign_r <= t_val[NX_W];
      end
      lnf_pkg::OP_TAKE_Y: begin
        y_r <= ysign_r ? -$signed(y_abs) : $signed(y_abs);
      end
      lnf_pkg::OP_MUL: begin
        prod_r <= y_r * w_r;
      end
      lnf_pkg::OP_SUM: begin
        // without affine the y/256 rounding equals (y*256)/65536
        acc_r <= aff_r ? (ACC_W'(prod_r) + (ACC_W'(b_r) <<< 16)) : (ACC_W'(y_r) <<< 8);
      end
      lnf_pkg::OP_LOAD: begin
        out_norm_r <= $signed(res_val);
        out_avg_r  <= last ? $signed(mean_r) : 16'sd0;
        out_inv_r  <= last ? rstd_r : 16'd0;
        out_fin_r  <= last;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.full      = (count_r == CNT_W'(MAX_LEN - 1));
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.last      = last;
    stat.out_free  = out_free;
  end

  assign out_valid             = out_valid_r;
  assign out_normalized        = out_norm_r;
  assign out_slice_average     = out_avg_r;
  assign out_inverse_deviation = out_inv_r;
  assign out_final_result      = out_fin_r;

endmodule

`default_nettype wire

>>> hw/rtl/lnf_ctrl.sv
// sequencer: collect a slice, compute statistics, then emit each element
`default_nettype none

module lnf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_slice_end,
  output logic                    in_stall,
  input  wire lnf_pkg::lnf_stat_t stat,
  output lnf_pkg::lnf_cmd_t       cmd
);

  localparam logic [4:0] S_ACC   = 5'd0;
  localparam logic [4:0] S_PROD  = 5'd1;
  localparam logic [4:0] S_DIFF  = 5'd2;
  localparam logic [4:0] S_VGO   = 5'd3;
  localparam logic [4:0] S_VWAIT = 5'd4;
  localparam logic [4:0] S_VTAKE = 5'd5;
  localparam logic [4:0] S_SGO   = 5'd6;
  localparam logic [4:0] S_SWAIT = 5'd7;
  localparam logic [4:0] S_STAKE = 5'd8;
  localparam logic [4:0] S_RGO   = 5'd9;
  localparam logic [4:0] S_RWAIT = 5'd10;
  localparam logic [4:0] S_RTAKE = 5'd11;
  localparam logic [4:0] S_MGO   = 5'd12;
  localparam logic [4:0] S_MWAIT = 5'd13;
  localparam logic [4:0] S_MTAKE = 5'd14;
  localparam logic [4:0] S_RD    = 5'd15;
  localparam logic [4:0] S_NX    = 5'd16;
  localparam logic [4:0] S_YGO   = 5'd17;
  localparam logic [4:0] S_YWAIT = 5'd18;
  localparam logic [4:0] S_YTAKE = 5'd19;
  localparam logic [4:0] S_MUL   = 5'd20;
  localparam logic [4:0] S_SUM   = 5'd21;
  localparam logic [4:0] S_LOAD  = 5'd22;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.op     = lnf_pkg::OP_NONE;
    in_stall   = 1'b1;
    case (state_r)
      S_ACC: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        // a full buffer closes the slice as if marked
        if (in_valid && (in_slice_end || stat.full)) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.op    = lnf_pkg::OP_PROD;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = lnf_pkg::OP_DIFF;
        state_nxt = S_VGO;
      end
      S_VGO: begin
        cmd.op    = lnf_pkg::OP_DIV_VAR;
        state_nxt = S_VWAIT;
      end
      S_VWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_VTAKE;
        end
      end
      S_VTAKE: begin
        cmd.op    = lnf_pkg::OP_TAKE_VAR;
        state_nxt = S_SGO;
      end
      S_SGO: begin
        cmd.op    = lnf_pkg::OP_SQRT;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (stat.sqrt_done) begin
          state_nxt = S_STAKE;
        end
      end
      S_STAKE: begin
        cmd.op    = lnf_pkg::OP_TAKE_SD;
        state_nxt = S_RGO;
      end
      S_RGO: begin
        cmd.op    = lnf_pkg::OP_DIV_RSTD;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_RTAKE;
        end
      end
      S_RTAKE: begin
        cmd.op    = lnf_pkg::OP_TAKE_RSTD;
        state_nxt = S_MGO;
      end
      S_MGO: begin
        cmd.op    = lnf_pkg::OP_DIV_MEAN;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_MTAKE;
        end
      end
      S_MTAKE: begin
        cmd.op    = lnf_pkg::OP_TAKE_MEAN;
        state_nxt = S_RD;
      end
      S_RD: begin
        // ram read of the current element in flight
        state_nxt = S_NX;
      end
      S_NX: begin
        cmd.op    = lnf_pkg::OP_NX;
        state_nxt = S_YGO;
      end
      S_YGO: begin
        cmd.op    = lnf_pkg::OP_DIV_Y;
        state_nxt = S_YWAIT;
      end
      S_YWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_YTAKE;
        end
      end
      S_YTAKE: begin
        cmd.op    = lnf_pkg::OP_TAKE_Y;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = lnf_pkg::OP_MUL;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = lnf_pkg::OP_SUM;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.op    = lnf_pkg::OP_LOAD;
          state_nxt = stat.last ? S_ACC : S_RD;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/layer_norm_forward.sv
// layer normalization forward pass with optional affine step, top level
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  sample, scale_weight, shift_bias, slice_end
// out      output     out_valid / out_stall normalized, slice_average, inverse_deviation,
//                                           final_result
// cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// elements are taken one per cycle while a slice is collected; the slice
// closes on slice_end or when MAX_LEN elements are held
// statistics then follow, and each result in turn, both set by the
// one-bit-per-cycle shared divider of width NUM_W (48 at MAX_LEN 64)
// input is stalled from the slice end until the last result is loaded into the
// result register; output stall holds that register and the sequencer before each load
// synchronous active low reset; buffer contents are not cleared
`default_nettype none

module layer_norm_forward #(
  parameter int MAX_LEN = lnf_pkg::MAX_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [15:0]            in_sample,
  input  wire logic signed [15:0]            in_scale_weight,
  input  wire logic signed [15:0]            in_shift_bias,
  input  wire logic                          in_slice_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [15:0]                 out_normalized,
  output logic signed [15:0]                 out_slice_average,
  output logic        [15:0]                 out_inverse_deviation,
  output logic                               out_final_result,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  lnf_pkg::lnf_cmd_t  cmd;
  lnf_pkg::lnf_stat_t stat;

  lnf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_slice_end (in_slice_end),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  lnf_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_sample             (in_sample),
    .in_scale_weight       (in_scale_weight),
    .in_shift_bias         (in_shift_bias),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_normalized        (out_normalized),
    .out_slice_average     (out_slice_average),
    .out_inverse_deviation (out_inverse_deviation),
    .out_final_result      (out_final_result)
  );

endmodule

`default_nettype wire
